>>> rtl/u8d_pkg.sv
`default_nettype none
package u8d_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CodeW  = 21;
    localparam int unsigned CountW = 16;

    // Register indexes on the configuration port
    localparam logic CfgMaxSymbols = 1'b0;
    localparam logic CfgStopAtNul  = 1'b1;

    localparam logic [CountW-1:0] MaxSymbolsReset = 16'hFFFF;

    // Lead byte patterns and payload masks
    localparam logic [ByteW-1:0] Lead2Mask  = 8'hE0;
    localparam logic [ByteW-1:0] Lead2Code  = 8'hC0;
    localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
    localparam logic [ByteW-1:0] Lead3Code  = 8'hE0;
    localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
    localparam logic [ByteW-1:0] Lead4Code  = 8'hF0;
    localparam logic [ByteW-1:0] ContMask   = 8'hC0;
    localparam logic [ByteW-1:0] ContCode   = 8'h80;
    localparam logic [ByteW-1:0] Pay1Mask   = 8'h7F;
    localparam logic [ByteW-1:0] Pay2Mask   = 8'h1F;
    localparam logic [ByteW-1:0] Pay3Mask   = 8'h0F;
    localparam logic [ByteW-1:0] Pay4Mask   = 8'h07;
    localparam logic [ByteW-1:0] ContPayMask = 8'h3F;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             last_byte;
    } in_item_t;

    typedef struct packed {
        logic              is_summary;
        logic [CodeW-1:0]  code_point;
        logic [CountW-1:0] symbol_count;
        logic [CountW-1:0] bytes_converted;
    } out_item_t;

    // Results produced by one accepted byte, symbol first
    typedef struct packed {
        logic      sym_valid;
        logic      sum_valid;
        out_item_t sym;
        out_item_t sum;
    } push_t;

endpackage
`default_nettype wire

>>> rtl/u8d_core.sv
`default_nettype none
module u8d_core #(
    parameter int unsigned COUNT_LIMIT = 65535
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [u8d_pkg::CountW-1:0] cfg_data,
    input  wire logic                      in_accept,
    input  wire u8d_pkg::in_item_t         in_item,
    output u8d_pkg::push_t                 push
);

    localparam logic [u8d_pkg::CountW-1:0] Limit = u8d_pkg::CountW'(COUNT_LIMIT);

    logic [u8d_pkg::CountW-1:0] max_symbols_reg;
    logic                       stop_at_nul_reg;

    logic [u8d_pkg::CodeW-1:0]  acc_reg, acc_next;
    logic [1:0]                 pending_reg, pending_next;
    logic [2:0]                 char_len_reg, char_len_next;
    logic                       halted_reg, halted_next;
    logic [u8d_pkg::CountW-1:0] syms_reg, syms_next;
    logic [u8d_pkg::CountW-1:0] bytes_reg, bytes_next;

    logic [u8d_pkg::CountW-1:0] limit;
    logic [2:0]                 lead_len;
    logic [u8d_pkg::ByteW-1:0]  lead_mask;
    logic [u8d_pkg::CountW:0]   bytes_sum;
    logic                       emit;
    logic [u8d_pkg::ByteW-1:0]  b;

    assign b     = in_item.data_byte;
    assign limit = (max_symbols_reg < Limit) ? max_symbols_reg : Limit;

    always_comb begin
        lead_len  = 3'd0;
        lead_mask = '0;
        if (!b[7]) begin
            lead_len  = 3'd1;
            lead_mask = u8d_pkg::Pay1Mask;
        end else if ((b & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Code) begin
            lead_len  = 3'd2;
            lead_mask = u8d_pkg::Pay2Mask;
        end else if ((b & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Code) begin
            lead_len  = 3'd3;
            lead_mask = u8d_pkg::Pay3Mask;
        end else if ((b & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Code) begin
            lead_len  = 3'd4;
            lead_mask = u8d_pkg::Pay4Mask;
        end
    end

    always_comb begin
        acc_next      = acc_reg;
        pending_next  = pending_reg;
        char_len_next = char_len_reg;
        halted_next   = halted_reg;
        syms_next     = syms_reg;
        bytes_next    = bytes_reg;
        emit          = 1'b0;
        bytes_sum     = '0;
        push          = '0;

        if (!halted_reg) begin
            if (pending_reg == 2'd0) begin
                if (syms_reg >= limit || lead_len == 3'd0
                        || (stop_at_nul_reg && b == '0)) begin
                    halted_next   = 1'b1;
                    acc_next      = '0;
                    char_len_next = '0;
                end else begin
                    acc_next      = u8d_pkg::CodeW'(b & lead_mask);
                    char_len_next = lead_len;
                    pending_next  = 2'(lead_len - 3'd1);
                    emit          = (lead_len == 3'd1);
                end
            end else if ((b & u8d_pkg::ContMask) != u8d_pkg::ContCode) begin
                halted_next   = 1'b1;
                acc_next      = '0;
                pending_next  = '0;
                char_len_next = '0;
            end else begin
                acc_next     = {acc_reg[u8d_pkg::CodeW-7:0], b[5:0]};
                pending_next = pending_reg - 2'd1;
                emit         = (pending_reg == 2'd1);
            end
        end

        if (emit) begin
            push.sym_valid       = 1'b1;
            push.sym.is_summary  = 1'b0;
            push.sym.code_point  = acc_next;
            if (syms_reg < Limit) begin
                syms_next = syms_reg + 1'b1;
            end
            bytes_sum  = {1'b0, bytes_reg} + (u8d_pkg::CountW+1)'(char_len_next);
            bytes_next = (bytes_sum > {1'b0, Limit}) ? Limit
                                                     : bytes_sum[u8d_pkg::CountW-1:0];
            acc_next      = '0;
            pending_next  = '0;
            char_len_next = '0;
        end

        if (in_item.last_byte) begin
            push.sum_valid            = 1'b1;
            push.sum.is_summary       = 1'b1;
            push.sum.symbol_count     = syms_next;
            push.sum.bytes_converted  = bytes_next;
            acc_next      = '0;
            pending_next  = '0;
            char_len_next = '0;
            halted_next   = 1'b0;
            syms_next     = '0;
            bytes_next    = '0;
        end

        if (!in_accept) begin
            push = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_symbols_reg <= u8d_pkg::MaxSymbolsReset;
            stop_at_nul_reg <= 1'b0;
            acc_reg         <= '0;
            pending_reg     <= '0;
            char_len_reg    <= '0;
            halted_reg      <= 1'b0;
            syms_reg        <= '0;
            bytes_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    u8d_pkg::CfgMaxSymbols: max_symbols_reg <= cfg_data;
                    u8d_pkg::CfgStopAtNul:  stop_at_nul_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                acc_reg      <= acc_next;
                pending_reg  <= pending_next;
                char_len_reg <= char_len_next;
                halted_reg   <= halted_next;
                syms_reg     <= syms_next;
                bytes_reg    <= bytes_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/u8d_out_fifo.sv
`default_nettype none
module u8d_out_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire u8d_pkg::push_t     push,
    output logic                    room,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output u8d_pkg::out_item_t      m_data
);

    localparam int unsigned Depth = 4;
    localparam int unsigned PtrW  = $clog2(Depth);

    u8d_pkg::out_item_t mem_reg [Depth];
    logic [PtrW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]      count_reg;
    logic [PtrW-1:0]    sum_ptr;
    logic               pop;
    logic [1:0]         n_push;

    // Two free entries cover the worst case of one byte
    assign room    = (count_reg <= (PtrW+1)'(Depth - 2));
    assign m_valid = (count_reg != '0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign n_push  = {1'b0, push.sym_valid} + {1'b0, push.sum_valid};
    assign sum_ptr = wr_ptr_reg + PtrW'(push.sym_valid);

    always_ff @(posedge aclk) begin
        if (push.sym_valid) begin
            mem_reg[wr_ptr_reg] <= push.sym;
        end
        if (push.sum_valid) begin
            mem_reg[sum_ptr] <= push.sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PtrW'(n_push);
            rd_ptr_reg <= rd_ptr_reg + PtrW'(pop);
            count_reg  <= count_reg + (PtrW+1)'(n_push) - (PtrW+1)'(pop);
        end
    end

endmodule
`default_nettype wire

>>> rtl/utf8_stream_decoder_top.sv
// UTF-8 stream decoder.
// Input channel (s_valid/s_ready/s_data): one byte of a string per transaction,
// with last_byte set on the final byte. Output channel (m_valid/m_ready/m_data):
// one decoded code point per completed character, then one summary transaction
// (is_summary = 1) with the symbol and byte counts after the last byte.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 = max_symbols,
// index 1 = stop_at_nul; write only while no string is in flight.
// A result enters the output queue when the byte that completes it is accepted.
// Throughput: one byte per cycle while s_ready is high. Bytes that produce no
// result or one result keep that rate; a last byte that also completes a
// character puts two transactions into the four-entry output queue, which
// drains one per cycle. s_ready is high while the queue has at least two free
// entries. When the receiver stalls, results wait in the queue and s_ready
// drops once more than two are held. Reset empties the queue, clears the string
// state and restores max_symbols to 65535 and stop_at_nul to 0.
`default_nettype none
module utf8_stream_decoder_top #(
    parameter int unsigned COUNT_LIMIT = 65535
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [u8d_pkg::CountW-1:0] cfg_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire u8d_pkg::in_item_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output u8d_pkg::out_item_t              m_data
);

    u8d_pkg::push_t push;
    logic           room;

    assign s_ready = room;

    u8d_core #(
        .COUNT_LIMIT(COUNT_LIMIT)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (s_valid && room),
        .in_item   (s_data),
        .push      (push)
    );

    u8d_out_fifo u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

>>> rtl/u8d_checker.sv
`default_nettype none
module u8d_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire u8d_pkg::out_item_t m_data
);

    // Queue is flushed by reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending right after reset");

    // Input only backs up when results are waiting
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with empty output queue");

    a_summary_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_summary |-> m_data.code_point == '0)
        else $error("summary carries a code point");

    a_symbol_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_summary
            |-> m_data.symbol_count == '0 && m_data.bytes_converted == '0)
        else $error("symbol carries counts");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_top u8d_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

>>> tb/utf8_stream_decoder_top_tb.sv
`timescale 1ns / 100ps
module utf8_stream_decoder_top_tb;

    localparam int unsigned CountLimit = 65535;
    localparam int QuietLimit = 1000;
    localparam int LongHold = 60;
    localparam int MaxPrinted = 20;

    typedef logic [7:0] byte_seq_t[$];

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic                           cfg_index;
    logic [u8d_pkg::CountW-1:0]     cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    u8d_pkg::in_item_t              s_data;
    logic                           m_valid;
    logic                           m_ready;
    u8d_pkg::out_item_t             m_data;

    // decoder state mirrored by the testbench
    logic [u8d_pkg::CountW-1:0]     max_syms;
    logic                           nul_stop;
    logic [u8d_pkg::CodeW-1:0]      acc;
    logic [1:0]                     cont_left;
    logic [2:0]                     char_len;
    bit                             stopped;
    int                             sym_cnt;
    int                             byte_cnt;

    u8d_pkg::out_item_t             decoded_q[$];
    byte_seq_t                      text_buf;

    bit                    idle_en;
    int                    hold_reqs;
    int                    hold_seen;
    int                    hold_left;
    int                    stall_left;
    int                    quiet_cycles;
    int                    errors;
    int                    bytes_sent;
    int                    bytes_decoded;
    int                    texts_sent;
    int                    symbols_checked;
    int                    summaries_checked;
    int                    settings_used;

    utf8_stream_decoder_top #(
        .COUNT_LIMIT(CountLimit)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_text_state();
        acc = '0;
        cont_left = '0;
        char_len = '0;
        stopped = 1'b0;
        sym_cnt = 0;
        byte_cnt = 0;
    endfunction

    function automatic void emit_char();
        u8d_pkg::out_item_t r;
        r = '0;
        r.code_point = acc;
        decoded_q.push_back(r);
        if (sym_cnt < CountLimit) sym_cnt++;
        byte_cnt = (byte_cnt + char_len > CountLimit) ? CountLimit : byte_cnt + char_len;
        acc = '0;
        cont_left = '0;
        char_len = '0;
    endfunction

    // Returns 1 when the byte is not simply ignored after a stop.
    function automatic bit decode_byte(input logic [7:0] b, input logic last);
        logic [2:0]         len;
        logic [7:0]         mask;
        int unsigned        sym_limit;
        u8d_pkg::out_item_t r;
        bit                 used;
        used = !stopped || last;
        if (!stopped) begin
            if (cont_left == 2'd0) begin
                sym_limit = (max_syms < CountLimit) ? max_syms : CountLimit;
                len = 3'd0;
                mask = 8'h00;
                if (!b[7]) begin
                    len = 3'd1;
                    mask = u8d_pkg::Pay1Mask;
                end else if ((b & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Code) begin
                    len = 3'd2;
                    mask = u8d_pkg::Pay2Mask;
                end else if ((b & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Code) begin
                    len = 3'd3;
                    mask = u8d_pkg::Pay3Mask;
                end else if ((b & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Code) begin
                    len = 3'd4;
                    mask = u8d_pkg::Pay4Mask;
                end
                if (sym_cnt >= sym_limit || len == 3'd0 || (nul_stop && b == 8'h00)) begin
                    stopped = 1'b1;
                    acc = '0;
                    char_len = '0;
                end else begin
                    acc = u8d_pkg::CodeW'(b & mask);
                    char_len = len;
                    cont_left = 2'(len - 3'd1);
                    if (cont_left == 2'd0) emit_char();
                end
            end else begin
                if ((b & u8d_pkg::ContMask) != u8d_pkg::ContCode) begin
                    stopped = 1'b1;
                    acc = '0;
                    cont_left = '0;
                    char_len = '0;
                end else begin
                    acc = {acc[u8d_pkg::CodeW-7:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) emit_char();
                end
            end
        end
        if (last) begin
            r = '0;
            r.is_summary = 1'b1;
            r.symbol_count = u8d_pkg::CountW'(sym_cnt);
            r.bytes_converted = u8d_pkg::CountW'(byte_cnt);
            decoded_q.push_back(r);
            clear_text_state();
        end
        return used;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MaxPrinted)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        u8d_pkg::in_item_t item;
        item.data_byte = b;
        item.last_byte = last;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        if (decode_byte(b, last)) bytes_decoded++;
    endtask

    // Sender goes quiet until every predicted result has been taken.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (decoded_q.size() != 0);
    endtask

    task automatic send_text(input int pause_at);
        foreach (text_buf[i]) begin
            if (i == pause_at) wait_drained();
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        texts_sent++;
    endtask

    task automatic apply_config(input logic [u8d_pkg::CountW-1:0] max_val,
                                input logic nul_val);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= u8d_pkg::CfgMaxSymbols;
        cfg_data <= max_val;
        @(posedge aclk);
        cfg_index <= u8d_pkg::CfgStopAtNul;
        cfg_data <= u8d_pkg::CountW'(nul_val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        max_syms = max_val;
        nul_stop = nul_val;
        settings_used++;
    endtask

    // Mostly well-formed text with random code points, some with a stray
    // byte or a cut-off tail.
    task automatic build_random_text();
        int nchars;
        int len;
        logic [20:0] p;
        text_buf = {};
        nchars = $urandom_range(1, 8);
        repeat (nchars) begin
            len = $urandom_range(1, 4);
            p = 21'($urandom);
            if (len == 1 && $urandom_range(0, 7) == 0) p = '0;
            case (len)
                1: text_buf.push_back({1'b0, p[6:0]});
                2: begin
                    text_buf.push_back({3'b110, p[10:6]});
                    text_buf.push_back({2'b10, p[5:0]});
                end
                3: begin
                    text_buf.push_back({4'b1110, p[15:12]});
                    text_buf.push_back({2'b10, p[11:6]});
                    text_buf.push_back({2'b10, p[5:0]});
                end
                default: begin
                    text_buf.push_back({5'b11110, p[20:18]});
                    text_buf.push_back({2'b10, p[17:12]});
                    text_buf.push_back({2'b10, p[11:6]});
                    text_buf.push_back({2'b10, p[5:0]});
                end
            endcase
        end
        case ($urandom_range(0, 9))
            0: text_buf.insert($urandom_range(0, text_buf.size()), 8'($urandom));
            1: if (text_buf.size() > 1) text_buf.delete(text_buf.size() - 1);
            default: ;
        endcase
    endtask

    task automatic send_random_until(input int byte_budget, input bit with_pauses);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget) begin
            build_random_text();
            if (with_pauses && $urandom_range(0, 11) == 0) begin
                send_text($urandom_range(0, text_buf.size() - 1));
                wait_drained();
            end else begin
                send_text(-1);
            end
        end
    endtask

    task automatic test_char_lengths();
        // NUL as U+0000, top of each length, last byte completes a char
        text_buf = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                     8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_text(-1);
    endtask

    task automatic test_malformed();
        text_buf = '{8'h41, 8'h85, 8'h42};
        send_text(-1);
        text_buf = '{8'hFF};
        send_text(-1);
        text_buf = '{8'hC3, 8'h41};
        send_text(-1);
        text_buf = '{8'hE2, 8'h82};
        send_text(-1);
    endtask

    task automatic test_nul_and_limit();
        apply_config(16'd2, 1'b1);
        text_buf = '{8'h41, 8'h00, 8'h42};
        send_text(-1);
        text_buf = '{8'h41, 8'h42, 8'h43};
        send_text(-1);
        apply_config(16'd0, 1'b0);
        text_buf = '{8'h41};
        send_text(-1);
    endtask

    task automatic test_random_settings();
        logic [u8d_pkg::CountW-1:0] max_val;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: max_val = u8d_pkg::MaxSymbolsReset;
                1: max_val = '0;
                2: max_val = 16'd1;
                default: max_val = ($urandom_range(0, 2) == 0)
                                   ? u8d_pkg::MaxSymbolsReset
                                   : u8d_pkg::CountW'($urandom_range(2, 12));
            endcase
            apply_config(max_val, 1'($urandom_range(0, 1)));
            send_random_until((max_val == 0) ? 30 : 120, 1'b1);
        end
    endtask

    task automatic test_output_stall();
        apply_config(u8d_pkg::MaxSymbolsReset, 1'b0);
        idle_en <= 1'b0;
        hold_reqs <= hold_reqs + 1;
        send_random_until(60, 1'b0);
        idle_en <= 1'b1;
    endtask

    task automatic test_pause_until_drained();
        repeat (5) begin
            build_random_text();
            send_text($urandom_range(0, text_buf.size() - 1));
            wait_drained();
        end
    endtask

    task automatic test_no_idle();
        apply_config(u8d_pkg::CountW'($urandom_range(3, 10)), 1'b1);
        idle_en <= 1'b0;
        send_random_until(100, 1'b0);
    endtask

    // Output side: random short stalls, plus one long hold on request.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            m_ready <= 1'b0;
            hold_seen <= hold_reqs;
            hold_left <= LongHold - 1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        u8d_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("result transaction with nothing expected",
                                32'(m_data.code_point), 32'd0);
            end else begin
                want = decoded_q.pop_front();
                if (m_data.is_summary !== want.is_summary)
                    report_mismatch("is_summary", 32'(m_data.is_summary),
                                    32'(want.is_summary));
                if (m_data.code_point !== want.code_point)
                    report_mismatch("code_point", 32'(m_data.code_point),
                                    32'(want.code_point));
                if (m_data.symbol_count !== want.symbol_count)
                    report_mismatch("symbol_count", 32'(m_data.symbol_count),
                                    32'(want.symbol_count));
                if (m_data.bytes_converted !== want.bytes_converted)
                    report_mismatch("bytes_converted", 32'(m_data.bytes_converted),
                                    32'(want.bytes_converted));
                if (want.is_summary) summaries_checked++;
                else symbols_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("timeout: no transaction for %0d cycles", QuietLimit);
            $display("utf8_stream_decoder_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= u8d_pkg::CfgMaxSymbols;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_data <= '0;
        m_ready <= 1'b0;
        idle_en <= 1'b1;
        hold_reqs <= 0;
        hold_seen = 0;
        hold_left = 0;
        stall_left = 0;
        quiet_cycles = 0;
        errors = 0;
        bytes_sent = 0;
        bytes_decoded = 0;
        texts_sent = 0;
        symbols_checked = 0;
        summaries_checked = 0;
        settings_used = 1;
        max_syms = u8d_pkg::MaxSymbolsReset;
        nul_stop = 1'b0;
        clear_text_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_char_lengths();
        test_malformed();
        test_nul_and_limit();
        test_random_settings();
        test_output_stall();
        test_pause_until_drained();
        test_no_idle();

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("%0d strings, %0d bytes sent (%0d not ignored), %0d register settings",
                 texts_sent, bytes_sent, bytes_decoded, settings_used);
        $display("%0d code points and %0d summaries checked, %0d mismatches",
                 symbols_checked, summaries_checked, errors);
        if (errors == 0) begin
            $display("utf8_stream_decoder_top_tb: PASS");
        end else begin
            $display("utf8_stream_decoder_top_tb: FAIL");
        end
        $finish;
    end

endmodule
